>>> rtl/core/sip_pkg.sv
// Shared types and constants for the segment intersection point block.
`timescale 1ns / 1ps
package sip_pkg;
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int DEN_BITS   = PROD_BITS + 1;
    localparam int MX1_BITS   = COORD_BITS + DEN_BITS;
    localparam int MX2_BITS   = DEN_BITS + DIFF_BITS;
    localparam int NUM_BITS   = MX2_BITS + 1;
    localparam int OUT_BITS   = 24;
    localparam int REM_LO     = OUT_BITS - FRAC_BITS;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_start_x;
        logic signed [COORD_BITS-1:0] first_start_y;
        logic signed [COORD_BITS-1:0] first_end_x;
        logic signed [COORD_BITS-1:0] first_end_y;
        logic signed [COORD_BITS-1:0] second_start_x;
        logic signed [COORD_BITS-1:0] second_start_y;
        logic signed [COORD_BITS-1:0] second_end_x;
        logic signed [COORD_BITS-1:0] second_end_y;
    } t_in;

    typedef struct packed {
        logic                       hit;
        logic signed [OUT_BITS-1:0] cross_x;
        logic signed [OUT_BITS-1:0] cross_y;
    } t_out;

    // Classified item handed from the front end to the divider.
    typedef struct packed {
        logic                hit;
        logic                neg_x;
        logic                neg_y;
        logic [NUM_BITS-1:0] mag_x;
        logic [NUM_BITS-1:0] mag_y;
        logic [DEN_BITS-1:0] mag_d;
    } t_mid;
endpackage

>>> rtl/core/sip_front.sv
// Front end: cross products, range classification and numerators.
`timescale 1ns / 1ps
module sip_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  sip_pkg::t_in  i_item,
    output logic          o_push,
    input  logic          i_q_full,
    output sip_pkg::t_mid o_mid
);
    import sip_pkg::*;

    function automatic logic in_unit(input logic signed [DEN_BITS-1:0] num,
                                     input logic signed [DEN_BITS-1:0] den);
        if (den > 0) begin
            return (num >= 0) && (num <= den);
        end
        return (num <= 0) && (num >= den);
    endfunction

    logic en;
    logic [5:1] r_v;

    logic signed [DIFF_BITS-1:0] r1_d1x, r1_d1y, r1_d2x, r1_d2y, r1_wx, r1_wy;
    logic signed [COORD_BITS-1:0] r1_ax, r1_ay, r2_ax, r2_ay, r3_ax, r3_ay;
    logic signed [PROD_BITS-1:0] r2_p1, r2_p2, r2_p3, r2_p4, r2_p5, r2_p6;
    logic signed [DIFF_BITS-1:0] r2_d1x, r2_d1y, r3_d1x, r3_d1y;
    logic signed [DEN_BITS-1:0]  r3_den, r3_t, r4_den;
    logic                        r3_hit, r4_hit;
    logic signed [MX1_BITS-1:0]  r4_mx1, r4_my1;
    logic signed [MX2_BITS-1:0]  r4_mx2, r4_my2;
    logic signed [NUM_BITS-1:0]  n_nx, n_ny;
    logic signed [DEN_BITS-1:0]  n_s;
    t_mid                        r5_mid;

    assign en     = !r_v[5] || !i_q_full;
    assign o_full = !en;
    assign o_push = r_v[5] && !i_q_full;
    assign o_mid  = r5_mid;

    assign n_s  = DEN_BITS'(r2_p3) - DEN_BITS'(r2_p4);
    assign n_nx = NUM_BITS'(r4_mx1) + NUM_BITS'(r4_mx2);
    assign n_ny = NUM_BITS'(r4_my1) + NUM_BITS'(r4_my2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[4:1], i_push};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_d1x <= DIFF_BITS'(i_item.first_end_x) - DIFF_BITS'(i_item.first_start_x);
            r1_d1y <= DIFF_BITS'(i_item.first_end_y) - DIFF_BITS'(i_item.first_start_y);
            r1_d2x <= DIFF_BITS'(i_item.second_end_x) - DIFF_BITS'(i_item.second_start_x);
            r1_d2y <= DIFF_BITS'(i_item.second_end_y) - DIFF_BITS'(i_item.second_start_y);
            r1_wx  <= DIFF_BITS'(i_item.first_start_x) - DIFF_BITS'(i_item.second_start_x);
            r1_wy  <= DIFF_BITS'(i_item.first_start_y) - DIFF_BITS'(i_item.second_start_y);
            r1_ax  <= i_item.first_start_x;
            r1_ay  <= i_item.first_start_y;

            r2_p1  <= PROD_BITS'(r1_d1x) * PROD_BITS'(r1_d2y);
            r2_p2  <= PROD_BITS'(r1_d2x) * PROD_BITS'(r1_d1y);
            r2_p3  <= PROD_BITS'(r1_d1x) * PROD_BITS'(r1_wy);
            r2_p4  <= PROD_BITS'(r1_d1y) * PROD_BITS'(r1_wx);
            r2_p5  <= PROD_BITS'(r1_d2x) * PROD_BITS'(r1_wy);
            r2_p6  <= PROD_BITS'(r1_d2y) * PROD_BITS'(r1_wx);
            r2_d1x <= r1_d1x;
            r2_d1y <= r1_d1y;
            r2_ax  <= r1_ax;
            r2_ay  <= r1_ay;

            r3_den <= DEN_BITS'(r2_p1) - DEN_BITS'(r2_p2);
            r3_t   <= DEN_BITS'(r2_p5) - DEN_BITS'(r2_p6);
            r3_hit <= (r2_p1 != r2_p2) && in_unit(n_s, DEN_BITS'(r2_p1) - DEN_BITS'(r2_p2))
                      && in_unit(DEN_BITS'(r2_p5) - DEN_BITS'(r2_p6),
                                 DEN_BITS'(r2_p1) - DEN_BITS'(r2_p2));
            r3_d1x <= r2_d1x;
            r3_d1y <= r2_d1y;
            r3_ax  <= r2_ax;
            r3_ay  <= r2_ay;

            r4_mx1 <= MX1_BITS'(r3_ax) * MX1_BITS'(r3_den);
            r4_my1 <= MX1_BITS'(r3_ay) * MX1_BITS'(r3_den);
            r4_mx2 <= MX2_BITS'(r3_t) * MX2_BITS'(r3_d1x);
            r4_my2 <= MX2_BITS'(r3_t) * MX2_BITS'(r3_d1y);
            r4_den <= r3_den;
            r4_hit <= r3_hit;

            r5_mid.hit   <= r4_hit;
            r5_mid.neg_x <= n_nx[NUM_BITS-1] != r4_den[DEN_BITS-1];
            r5_mid.neg_y <= n_ny[NUM_BITS-1] != r4_den[DEN_BITS-1];
            r5_mid.mag_x <= n_nx[NUM_BITS-1] ? NUM_BITS'(-n_nx) : NUM_BITS'(n_nx);
            r5_mid.mag_y <= n_ny[NUM_BITS-1] ? NUM_BITS'(-n_ny) : NUM_BITS'(n_ny);
            r5_mid.mag_d <= r4_den[DEN_BITS-1] ? DEN_BITS'(-r4_den) : DEN_BITS'(r4_den);
        end
    end
endmodule

>>> rtl/core/sip_queue.sv
// Four-entry queue of classified items between the front end and the divider.
`timescale 1ns / 1ps
module sip_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sip_pkg::t_mid i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output sip_pkg::t_mid o_data
);
    import sip_pkg::*;

    t_mid       r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       wr, rd;

    assign o_full  = r_cnt == 3'd4;
    assign o_empty = r_cnt == 3'd0;
    assign o_data  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 2'd1;
            if (rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(wr) - 3'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end
endmodule

>>> rtl/core/sip_back.sv
// Back end: pipelined restoring divider, one quotient bit a stage, and result queue.
`timescale 1ns / 1ps
module sip_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    output logic          o_pop,
    input  sip_pkg::t_mid i_mid,
    output logic          o_empty,
    input  logic          i_pop,
    output sip_pkg::t_out o_res
);
    import sip_pkg::*;

    localparam int N = OUT_BITS;

    logic                r_v   [N+1];
    logic                r_hit [N+1];
    logic                r_ngx [N+1];
    logic                r_ngy [N+1];
    logic [DEN_BITS-1:0] r_ud  [N+1];
    logic [DEN_BITS-1:0] r_rx  [N+1];
    logic [DEN_BITS-1:0] r_ry  [N+1];
    logic [N-1:0]        r_lx  [N+1];
    logic [N-1:0]        r_ly  [N+1];
    logic [N-1:0]        r_qx  [N+1];
    logic [N-1:0]        r_qy  [N+1];
    logic [DEN_BITS-1:0] n_rx  [N];
    logic [DEN_BITS-1:0] n_ry  [N];
    logic                n_bx  [N];
    logic                n_by  [N];

    logic       en, ofull, owr, ord;
    t_out       r_obuf [2];
    logic       r_owp, r_orp;
    logic [1:0] r_ocnt;
    t_out       res;

    function automatic logic [N-1:0] finish(input logic hit, input logic neg,
                                            input logic [N-1:0] q);
        if (!hit) return '0;
        if (neg) begin
            if (q[N-1] && (q[N-2:0] != '0)) return {1'b1, {(N-1){1'b0}}};
            return N'(-q);
        end
        if (q[N-1]) return {1'b0, {(N-1){1'b1}}};
        return q;
    endfunction

    assign ofull = r_ocnt == 2'd2;
    assign en    = !r_v[N] || !ofull;
    assign o_pop = en && !i_empty;
    assign owr   = r_v[N] && !ofull;
    assign ord   = i_pop && !o_empty;

    always_comb begin
        for (int k = 0; k < N; k++) begin
            logic [DEN_BITS:0] tx, ty;
            tx = {r_rx[k], r_lx[k][N-1]};
            ty = {r_ry[k], r_ly[k][N-1]};
            n_bx[k] = tx >= {1'b0, r_ud[k]};
            n_by[k] = ty >= {1'b0, r_ud[k]};
            n_rx[k] = n_bx[k] ? DEN_BITS'(tx - {1'b0, r_ud[k]}) : tx[DEN_BITS-1:0];
            n_ry[k] = n_by[k] ? DEN_BITS'(ty - {1'b0, r_ud[k]}) : ty[DEN_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= N; k++) r_v[k] <= 1'b0;
        end else if (en) begin
            r_v[0] <= !i_empty;
            for (int k = 0; k < N; k++) r_v[k+1] <= r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit[0] <= i_mid.hit;
            r_ngx[0] <= i_mid.neg_x;
            r_ngy[0] <= i_mid.neg_y;
            r_ud[0]  <= i_mid.mag_d;
            r_rx[0]  <= i_mid.mag_x[DEN_BITS+REM_LO-1:REM_LO];
            r_ry[0]  <= i_mid.mag_y[DEN_BITS+REM_LO-1:REM_LO];
            r_lx[0]  <= {i_mid.mag_x[REM_LO-1:0], {FRAC_BITS{1'b0}}};
            r_ly[0]  <= {i_mid.mag_y[REM_LO-1:0], {FRAC_BITS{1'b0}}};
            r_qx[0]  <= '0;
            r_qy[0]  <= '0;
            for (int k = 0; k < N; k++) begin
                r_hit[k+1] <= r_hit[k];
                r_ngx[k+1] <= r_ngx[k];
                r_ngy[k+1] <= r_ngy[k];
                r_ud[k+1]  <= r_ud[k];
                r_rx[k+1]  <= n_rx[k];
                r_ry[k+1]  <= n_ry[k];
                r_lx[k+1]  <= {r_lx[k][N-2:0], 1'b0};
                r_ly[k+1]  <= {r_ly[k][N-2:0], 1'b0};
                r_qx[k+1]  <= {r_qx[k][N-2:0], n_bx[k]};
                r_qy[k+1]  <= {r_qy[k][N-2:0], n_by[k]};
            end
        end
    end

    assign res.hit     = r_hit[N];
    assign res.cross_x = finish(r_hit[N], r_ngx[N], r_qx[N]);
    assign res.cross_y = finish(r_hit[N], r_ngy[N], r_qy[N]);

    assign o_empty = r_ocnt == 2'd0;
    assign o_res   = r_obuf[r_orp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= '0;
        end else begin
            if (owr) r_owp <= !r_owp;
            if (ord) r_orp <= !r_orp;
            r_ocnt <= r_ocnt + 2'(owr) - 2'(ord);
        end
    end

    always_ff @(posedge i_clk) begin
        if (owr) r_obuf[r_owp] <= res;
    end
endmodule

>>> rtl/core/segment_intersection_point.sv
// Top level of the segment intersection point block.
`timescale 1ns / 1ps
// The block takes one pair of integer line segments per cycle and reports whether they
// meet, touching endpoints included, and if so where, in signed fixed point with eight
// fraction bits truncated toward zero. Parallel, collinear and zero-length segments give
// no hit, and a result without a hit carries zero coordinates. Items enter while full is
// low and leave in order while empty is low; one item per cycle is sustained in both
// directions. On its way out a result passes through five front-end stages that form the
// cross products, classify the pair and build the numerators, an entry of the four-entry
// queue, a load stage and 24 divider stages that resolve one quotient bit each, and the
// two-entry result queue, from which it can be popped. Either side may stall without the
// other losing items, as the middle queue decouples the front end from the divider.
module segment_intersection_point (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  sip_pkg::t_in  i_item,
    output logic          empty,
    input  logic          pop,
    output sip_pkg::t_out o_result
);
    import sip_pkg::*;

    logic f_push, q_full, q_empty, q_pop;
    t_mid f_mid, q_mid;

    sip_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (i_item),
        .o_push  (f_push),
        .i_q_full(q_full),
        .o_mid   (f_mid)
    );

    sip_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_mid),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_mid)
    );

    sip_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .i_mid   (q_mid),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (o_result)
    );

    // Reset leaves no result waiting.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // A result without a hit must carry a zero point.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.hit) |-> (o_result.cross_x == 0 && o_result.cross_y == 0))
        else $error("miss with nonzero crossing point");

    // The middle queue only hands items over that it holds.
    a_queue_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("divider took an item from an empty queue");
endmodule
